### rtl/core/open_addressing_hash_insert_top_assert.svh
// Assertion macros for the open-addressing hash table top level.
`ifndef OPEN_ADDRESSING_HASH_INSERT_TOP_ASSERT_SVH
`define OPEN_ADDRESSING_HASH_INSERT_TOP_ASSERT_SVH

// Same-cycle implication, sampled on aclk, off during reset.
`define OAHI_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("oahi: same-cycle check failed");

// Next-cycle implication, sampled on aclk, off during reset.
`define OAHI_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("oahi: next-cycle check failed");

`endif

### rtl/core/oahi_pkg.sv
// Shared types and constants for the open-addressing hash table.
`timescale 1ns / 1ps

package oahi_pkg;

    localparam int KEY_W     = 31;
    localparam int SLOT_W    = 4;
    localparam int CNT_OUT_W = 5;
    localparam int REQ_W     = 2;
    localparam int STATUS_W  = 3;
    localparam int MODE_W    = 2;
    localparam int S_DATA_W  = 40;  // key + slot_index, padded to bytes
    localparam int M_DATA_W  = 40;  // slot + probe_count + key_out, exactly 40 bits

    typedef enum logic [REQ_W-1:0] {
        REQ_INSERT = 2'd0,
        REQ_READ   = 2'd1,
        REQ_CLEAR  = 2'd2
    } req_type_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED = 3'd0,
        ST_FULL     = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_OCCUPIED = 3'd3,
        ST_CLEARED  = 3'd4
    } status_t;

    typedef enum logic [MODE_W-1:0] {
        PM_LINEAR = 2'd0,
        PM_QUAD   = 2'd1,
        PM_QUAD2  = 2'd2,
        PM_DOUBLE = 2'd3
    } probe_mode_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_HASH1,
        S_HASH2,
        S_INIT,
        S_PROBE,
        S_RD,
        S_RD_DONE,
        S_CLR
    } state_t;

    // Controller -> datapath
    typedef struct packed {
        logic load;        // capture request fields
        logic init;        // load first probe position and stride
        logic step;        // advance to next probe
        logic ins_commit;  // store key, emit inserted
        logic full_emit;   // emit table full
        logic rd_en;       // read key memory
        logic rd_emit;     // emit read result
        logic clr_emit;    // clear used bits, emit cleared
    } dp_cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic slot_free;   // slot at current probe is empty
        logic last_probe;  // current probe is number TABLE_SIZE-1
        logic out_free;    // output register can take a result
    } dp_sts_t;

endpackage

### rtl/core/oahi_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module oahi_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/oahi_ctrl.sv
// Request sequencer: accepts requests and steps the datapath through them.
`timescale 1ns / 1ps

module oahi_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  oahi_pkg::req_type_t req_type,
    input  oahi_pkg::dp_sts_t   sts,
    output oahi_pkg::dp_cmd_t   cmd
);
    import oahi_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    case (req_type)
                        REQ_INSERT: state_next = S_HASH1;
                        REQ_READ:   state_next = S_RD;
                        REQ_CLEAR:  state_next = S_CLR;
                        default:    state_next = S_IDLE;  // unused code, dropped
                    endcase
                end
            end
            S_HASH1: state_next = S_HASH2;
            S_HASH2: state_next = S_INIT;
            S_INIT:  state_next = S_PROBE;
            S_PROBE: begin
                if ((sts.slot_free || sts.last_probe) && sts.out_free) begin
                    state_next = S_IDLE;
                end
            end
            S_RD:      state_next = S_RD_DONE;
            S_RD_DONE: begin
                if (sts.out_free) begin
                    state_next = S_IDLE;
                end
            end
            S_CLR: begin
                if (sts.out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            S_INIT: cmd.init = 1'b1;
            S_PROBE: begin
                if (sts.slot_free) begin
                    cmd.ins_commit = sts.out_free;
                end else if (sts.last_probe) begin
                    cmd.full_emit = sts.out_free;
                end else begin
                    cmd.step = 1'b1;
                end
            end
            S_RD:      cmd.rd_en    = 1'b1;
            S_RD_DONE: cmd.rd_emit  = sts.out_free;
            S_CLR:     cmd.clr_emit = sts.out_free;
            default: begin
                cmd      = '0;
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

### rtl/core/oahi_dp.sv
// Datapath: key hashing, probe position stepping, used bits, key memory, result register.
`timescale 1ns / 1ps

module oahi_dp #(
    parameter int TABLE_SIZE = 16
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    input  logic [oahi_pkg::MODE_W-1:0]      cfg_data,
    input  logic [oahi_pkg::KEY_W-1:0]       key,
    input  logic [oahi_pkg::SLOT_W-1:0]      slot_index,
    input  oahi_pkg::dp_cmd_t                cmd,
    output oahi_pkg::dp_sts_t                sts,
    input  logic                             m_tready,
    output logic                             m_tvalid,
    output oahi_pkg::status_t                m_status,
    output logic [oahi_pkg::SLOT_W-1:0]      m_slot,
    output logic [oahi_pkg::CNT_OUT_W-1:0]   m_probe_count,
    output logic [oahi_pkg::KEY_W-1:0]       m_key_out
);
    import oahi_pkg::*;

    localparam int IDX_W = (TABLE_SIZE > 2) ? $clog2(TABLE_SIZE) : 1;
    localparam int CNT_W = $clog2(TABLE_SIZE + 1);
    localparam int MW    = $clog2(TABLE_SIZE + 1);
    localparam int AW    = IDX_W + 1;
    localparam int VW    = (MW > 4) ? MW : 4;
    localparam int PROD_W = 63;

    // k mod M by reciprocal: q = (k * ceil(2^S / M)) >> S, exact for 31-bit k
    localparam int          SHIFT_M  = KEY_W + IDX_W;
    localparam logic [63:0] RECIP_MF = ((64'd1 << SHIFT_M) + 64'(TABLE_SIZE) - 64'd1)
                                       / 64'(TABLE_SIZE);
    localparam logic [31:0] RECIP_M  = RECIP_MF[31:0];
    localparam int          REM_M_W  = KEY_W + MW;

    // k mod 7 the same way
    localparam int          SHIFT_7  = KEY_W + 3;
    localparam logic [63:0] RECIP_7F = ((64'd1 << SHIFT_7) + 64'd6) / 64'd7;
    localparam logic [31:0] RECIP_7  = RECIP_7F[31:0];
    localparam int          REM_7_W  = KEY_W + 3;

    localparam logic [31:0] FULL_CNT = 32'(TABLE_SIZE);

    // reduce a value of at most 7 below TABLE_SIZE (TABLE_SIZE >= 2)
    function automatic logic [IDX_W-1:0] small_mod(input logic [3:0] x);
        logic [VW-1:0] v;
        v = VW'(x);
        for (int n = 0; n < 4; n++) begin
            if (v >= VW'(TABLE_SIZE)) begin
                v = v - VW'(TABLE_SIZE);
            end
        end
        return IDX_W'(v);
    endfunction

    probe_mode_t          mode_reg;
    logic [KEY_W-1:0]     key_reg;
    logic [SLOT_W-1:0]    idx_reg;
    logic [PROD_W-1:0]    mul_m_reg;
    logic [PROD_W-1:0]    mul_7_reg;
    logic [IDX_W-1:0]     kmod_m_reg;
    logic [2:0]           kmod_7_reg;
    logic [IDX_W-1:0]     pos_reg;
    logic [IDX_W-1:0]     pos_next;
    logic [IDX_W-1:0]     delta_reg;
    logic [IDX_W-1:0]     delta_next;
    logic [CNT_W-1:0]     probe_idx_reg;
    logic [TABLE_SIZE-1:0] used_reg;

    logic                 m_valid_reg;
    status_t              m_status_reg;
    logic [SLOT_W-1:0]    m_slot_reg;
    logic [CNT_OUT_W-1:0] m_count_reg;
    logic [KEY_W-1:0]     m_key_reg;

    logic [PROD_W-1:0]    q_m_full;
    logic [PROD_W-1:0]    q_7_full;
    logic [REM_M_W-1:0]   rem_m;
    logic [REM_7_W-1:0]   rem_7;
    logic [AW-1:0]        pos_sum;
    logic [AW-1:0]        delta_sum;
    logic [IDX_W-1:0]     delta_init;
    logic [31:0]          pos_ext;
    logic [31:0]          idx_ext;
    logic [31:0]          cnt_ext;
    logic [IDX_W-1:0]     idx_w;
    logic                 idx_in_range;
    logic                 rd_occupied;
    logic [KEY_W-1:0]     ram_rdata;
    logic                 out_free;

    // configuration register; the port is always ready
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= PM_LINEAR;
        end else if (cfg_valid) begin
            mode_reg <= probe_mode_t'(cfg_data);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            key_reg <= key;
            idx_reg <= slot_index;
        end
    end

    // hash pipeline: products, then remainders
    assign q_m_full = mul_m_reg >> SHIFT_M;
    assign q_7_full = mul_7_reg >> SHIFT_7;
    assign rem_m = REM_M_W'(key_reg) - REM_M_W'(q_m_full[KEY_W-1:0]) * REM_M_W'(TABLE_SIZE);
    assign rem_7 = REM_7_W'(key_reg) - REM_7_W'(q_7_full[KEY_W-1:0]) * REM_7_W'(7);

    always_ff @(posedge aclk) begin
        mul_m_reg  <= PROD_W'(key_reg) * PROD_W'(RECIP_M);
        mul_7_reg  <= PROD_W'(key_reg) * PROD_W'(RECIP_7);
        kmod_m_reg <= rem_m[IDX_W-1:0];
        kmod_7_reg <= rem_7[2:0];
    end

    // stride from probe i to i+1, kept below TABLE_SIZE
    always_comb begin
        case (mode_reg)
            PM_LINEAR: delta_init = small_mod(4'd1);
            PM_QUAD:   delta_init = small_mod(4'd1);
            PM_QUAD2:  delta_init = small_mod(4'd3);
            PM_DOUBLE: delta_init = small_mod(4'd7 - {1'b0, kmod_7_reg});
            default:   delta_init = small_mod(4'd1);
        endcase
    end

    assign pos_sum   = AW'(pos_reg) + AW'(delta_reg);
    assign delta_sum = AW'(delta_reg) + AW'(2);

    always_comb begin
        if (pos_sum >= AW'(TABLE_SIZE)) begin
            pos_next = IDX_W'(pos_sum - AW'(TABLE_SIZE));
        end else begin
            pos_next = pos_sum[IDX_W-1:0];
        end
        // quadratic strides grow by two each probe
        if (mode_reg == PM_QUAD || mode_reg == PM_QUAD2) begin
            if (delta_sum >= AW'(TABLE_SIZE)) begin
                delta_next = IDX_W'(delta_sum - AW'(TABLE_SIZE));
            end else begin
                delta_next = delta_sum[IDX_W-1:0];
            end
        end else begin
            delta_next = delta_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.init) begin
            pos_reg       <= kmod_m_reg;
            delta_reg     <= delta_init;
            probe_idx_reg <= '0;
        end else if (cmd.step) begin
            pos_reg       <= pos_next;
            delta_reg     <= delta_next;
            probe_idx_reg <= probe_idx_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg <= '0;
        end else if (cmd.clr_emit) begin
            used_reg <= '0;
        end else if (cmd.ins_commit) begin
            used_reg[pos_reg] <= 1'b1;
        end
    end

    assign idx_ext      = 32'(idx_reg);
    assign idx_w        = idx_ext[IDX_W-1:0];
    assign idx_in_range = idx_ext < FULL_CNT;
    assign rd_occupied  = idx_in_range && used_reg[idx_w];

    oahi_ram #(
        .WIDTH (KEY_W),
        .DEPTH (TABLE_SIZE)
    ) u_keys (
        .aclk  (aclk),
        .we    (cmd.ins_commit),
        .waddr (pos_reg),
        .wdata (key_reg),
        .re    (cmd.rd_en),
        .raddr (idx_w),
        .rdata (ram_rdata)
    );

    assign pos_ext  = 32'(pos_reg);
    assign cnt_ext  = 32'(probe_idx_reg + CNT_W'(1));
    assign out_free = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.ins_commit || cmd.full_emit || cmd.rd_emit || cmd.clr_emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.ins_commit) begin
            m_status_reg <= ST_INSERTED;
            m_slot_reg   <= pos_ext[SLOT_W-1:0];
            m_count_reg  <= cnt_ext[CNT_OUT_W-1:0];
            m_key_reg    <= '0;
        end else if (cmd.full_emit) begin
            m_status_reg <= ST_FULL;
            m_slot_reg   <= '0;
            m_count_reg  <= FULL_CNT[CNT_OUT_W-1:0];
            m_key_reg    <= '0;
        end else if (cmd.rd_emit) begin
            m_status_reg <= rd_occupied ? ST_OCCUPIED : ST_EMPTY;
            m_slot_reg   <= idx_reg;
            m_count_reg  <= '0;
            m_key_reg    <= rd_occupied ? ram_rdata : '0;
        end else if (cmd.clr_emit) begin
            m_status_reg <= ST_CLEARED;
            m_slot_reg   <= '0;
            m_count_reg  <= '0;
            m_key_reg    <= '0;
        end
    end

    assign sts.slot_free  = !used_reg[pos_reg];
    assign sts.last_probe = probe_idx_reg == CNT_W'(TABLE_SIZE - 1);
    assign sts.out_free   = out_free;

    assign m_tvalid      = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_slot        = m_slot_reg;
    assign m_probe_count = m_count_reg;
    assign m_key_out     = m_key_reg;

endmodule

### rtl/core/open_addressing_hash_insert_top.sv
// Top level: open-addressing hash table with selectable probe rule.
// Insert steps: HASH1 and HASH2 form the reciprocal hash, INIT loads the first probe, then PROBE
// tests one used bit per cycle, at most TABLE_SIZE probes. Read steps: RD, RD_DONE. Clear: CLR.
// A result waits for room in the output register; no new request is taken until it is loaded.
// Reset (aresetn low, sync): used bits cleared, probe_mode 0, output empty; key RAM not cleared.
`timescale 1ns / 1ps
`include "open_addressing_hash_insert_top_assert.svh"

module open_addressing_hash_insert_top #(
    parameter int TABLE_SIZE = 16  // number of slots, 2..16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // request channel
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [oahi_pkg::S_DATA_W-1:0]     s_tdata,   // key[30:0], slot_index[34:31], zero pad
    input  logic [oahi_pkg::REQ_W-1:0]        s_tuser,   // req_type[1:0]
    // result channel
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [oahi_pkg::M_DATA_W-1:0]     m_tdata,   // slot[3:0], probe_count[8:4],
                                                         // key_out[39:9]
    output logic [oahi_pkg::STATUS_W-1:0]     m_tuser,   // status[2:0]
    // probe_mode register write
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [oahi_pkg::MODE_W-1:0]       cfg_data
);
    import oahi_pkg::*;

    dp_cmd_t              cmd;
    dp_sts_t              sts;
    status_t              m_status;
    logic [SLOT_W-1:0]    m_slot;
    logic [CNT_OUT_W-1:0] m_probe_count;
    logic [KEY_W-1:0]     m_key_out;
    logic [3:0]           emit_vec;

    // register writes land immediately; the block is idle by contract
    assign cfg_ready = 1'b1;

    oahi_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .req_type (req_type_t'(s_tuser)),
        .sts      (sts),
        .cmd      (cmd)
    );

    oahi_dp #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_data      (cfg_data),
        .key           (s_tdata[KEY_W-1:0]),
        .slot_index    (s_tdata[KEY_W+SLOT_W-1:KEY_W]),
        .cmd           (cmd),
        .sts           (sts),
        .m_tready      (m_tready),
        .m_tvalid      (m_tvalid),
        .m_status      (m_status),
        .m_slot        (m_slot),
        .m_probe_count (m_probe_count),
        .m_key_out     (m_key_out)
    );

    // result transfer packing, low field first; the fields fill all five bytes
    assign m_tdata = {m_key_out, m_probe_count, m_slot};
    assign m_tuser = m_status;

    // every command that loads the output register
    assign emit_vec = {cmd.ins_commit, cmd.full_emit, cmd.rd_emit, cmd.clr_emit};

    // never two results launched in one cycle
    `OAHI_ASSERT_IMP(a_one_emit, 1'b1, $onehot0(emit_vec))
    // a result is only loaded when the output register has room
    `OAHI_ASSERT_IMP(a_emit_room, (|emit_vec), sts.out_free)
    // a committed insert shows up as an inserted result next cycle
    `OAHI_ASSERT_NXT(a_ins_result, cmd.ins_commit, (m_tvalid && m_tuser == ST_INSERTED))
    // requests are only taken while no probe is stepped and no result is emitted
    `OAHI_ASSERT_IMP(a_no_accept_busy, (s_tvalid && s_tready), !(cmd.step || |emit_vec))

endmodule

### tb/tb.sv
// Self-checking testbench for the open-addressing hash table top level.
`timescale 1ns / 1ps

module tb;
    import oahi_pkg::*;

    localparam int TABLE_SIZE = 16;
    localparam int DRAIN_CYCLES = TABLE_SIZE + 8;  // a dropped request code yields no transfer
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
    localparam logic [KEY_W-1:0] KEY_MAX = {KEY_W{1'b1}};
    localparam int ITEMS_PER_MODE = 83;

    typedef struct {
        status_t              status;
        logic [SLOT_W-1:0]    slot;
        logic [CNT_OUT_W-1:0] probes;
        logic [KEY_W-1:0]     key_out;
    } hash_result_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic [REQ_W-1:0]    s_tuser = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic [STATUS_W-1:0] m_tuser;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [MODE_W-1:0]   cfg_data = '0;

    // predictor state
    probe_mode_t        cur_mode = PM_LINEAR;
    bit                 slot_busy [TABLE_SIZE];
    logic [KEY_W-1:0]   slot_key_mem [TABLE_SIZE];
    hash_result_t       pending_results [$];
    hash_result_t       next_result;
    hash_result_t       want;

    int src_idle_pct = 0;
    int sink_stall_pct = 0;
    int fail_count = 0;
    int n_stored = 0, n_full = 0, n_hit = 0, n_miss = 0, n_clear = 0, n_unused = 0;

    open_addressing_hash_insert_top #(.TABLE_SIZE(TABLE_SIZE)) uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #4 aclk = ~aclk;

    function automatic int probe_slot(input logic [KEY_W-1:0] key, input int i);
        longint unsigned k, n, m;
        k = key;
        n = i;
        m = TABLE_SIZE;
        case (cur_mode)
            PM_LINEAR: return int'((k + n) % m);
            PM_QUAD:   return int'((k + n * n) % m);
            PM_QUAD2:  return int'((k + 2 * n + n * n) % m);
            default:   return int'((k % m + n * (7 - k % 7)) % m);
        endcase
    endfunction

    // Applies one request to the shadow table; returns 0 when no transfer follows.
    function automatic bit apply_request(input logic [REQ_W-1:0] req,
                                         input logic [KEY_W-1:0] key,
                                         input logic [SLOT_W-1:0] idx,
                                         output hash_result_t res);
        int pos;
        res.status  = ST_EMPTY;
        res.slot    = '0;
        res.probes  = '0;
        res.key_out = '0;
        case (req)
            REQ_INSERT: begin
                res.status = ST_FULL;
                res.probes = CNT_OUT_W'(TABLE_SIZE);
                for (int i = 0; i < TABLE_SIZE; i++) begin
                    pos = probe_slot(key, i);
                    if (!slot_busy[pos]) begin
                        slot_busy[pos]    = 1'b1;
                        slot_key_mem[pos] = key;
                        res.status = ST_INSERTED;
                        res.slot   = SLOT_W'(pos);
                        res.probes = CNT_OUT_W'(i + 1);
                        break;
                    end
                end
                if (res.status == ST_INSERTED) n_stored++;
                else n_full++;
            end
            REQ_READ: begin
                res.slot = idx;
                if (idx < TABLE_SIZE && slot_busy[idx]) begin
                    res.status  = ST_OCCUPIED;
                    res.key_out = slot_key_mem[idx];
                    n_hit++;
                end else begin
                    n_miss++;
                end
            end
            REQ_CLEAR: begin
                slot_busy = '{default: 1'b0};
                res.status = ST_CLEARED;
                n_clear++;
            end
            default: begin
                n_unused++;
                return 1'b0;
            end
        endcase
        return 1'b1;
    endfunction

    // Result check, request prediction and register tracking, all on sampled values.
    always @(posedge aclk) begin
        if (!aresetn) begin
            cur_mode = PM_LINEAR;
            slot_busy = '{default: 1'b0};
        end else begin
            if (m_tvalid && m_tready) begin
                if (pending_results.size() == 0) begin
                    $error("result transfer with nothing pending: status %0d, data %h",
                           m_tuser, m_tdata);
                    fail_count++;
                end else begin
                    want = pending_results.pop_front();
                    if (m_tuser !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, m_tuser);
                        fail_count++;
                    end
                    if (m_tdata[3:0] !== want.slot) begin
                        $error("slot: expected %0d, got %0d", want.slot, m_tdata[3:0]);
                        fail_count++;
                    end
                    if (m_tdata[8:4] !== want.probes) begin
                        $error("probe_count: expected %0d, got %0d", want.probes, m_tdata[8:4]);
                        fail_count++;
                    end
                    if (m_tdata[39:9] !== want.key_out) begin
                        $error("key_out: expected %0d, got %0d", want.key_out, m_tdata[39:9]);
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                if (apply_request(s_tuser, s_tdata[KEY_W-1:0], s_tdata[KEY_W +: SLOT_W],
                                  next_result))
                    pending_results.push_back(next_result);
            end
            if (cfg_valid && cfg_ready)
                cur_mode = probe_mode_t'(cfg_data);
        end
    end

    always @(posedge aclk) begin
        m_tready <= (sink_stall_pct == 0) || ($urandom_range(99) >= sink_stall_pct);
    end

    task automatic send_request(input logic [REQ_W-1:0] req, input logic [KEY_W-1:0] key,
                                input logic [SLOT_W-1:0] idx);
        if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < src_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {{(S_DATA_W - KEY_W - SLOT_W){1'b0}}, idx, key};
        do @(posedge aclk); while (!s_tready);
    endtask

    // Drain all pending results, then let any silent request finish.
    // The first edge lets the checker log the last accepted request.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_probe_mode(input probe_mode_t mode);
        cfg_valid <= 1'b1;
        cfg_data  <= mode;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [KEY_W-1:0] rand_key();
        case ($urandom_range(2))
            0:       return KEY_W'($urandom_range(63));  // small keys, repeated often
            1:       return KEY_W'($urandom);
            default: return KEY_MAX - KEY_W'($urandom_range(63));
        endcase
    endfunction

    // Empty reads, edge keys, a collision, the dropped code and a clear, at reset mode.
    task automatic test_basic_requests();
        send_request(REQ_READ, '0, '0);
        send_request(REQ_READ, KEY_MAX, 4'd15);
        send_request(REQ_INSERT, '0, 4'd15);
        send_request(REQ_INSERT, KEY_MAX, '0);
        send_request(REQ_INSERT, KEY_W'(16), '0);
        send_request(REQ_READ, '0, '0);
        send_request(REQ_READ, '0, 4'd15);
        send_request(REQ_UNUSED, KEY_MAX, 4'd15);
        send_request(REQ_CLEAR, '0, '0);
        send_request(REQ_READ, '0, 4'd15);
    endtask

    // Same key over and over: duplicates are stored until every slot is taken.
    task automatic test_fill_to_full();
        wait_idle();
        write_probe_mode(PM_LINEAR);
        repeat (TABLE_SIZE + 1) send_request(REQ_INSERT, KEY_W'(5), '0);
    endtask

    task automatic test_random_traffic(input int src_pct, input int sink_pct);
        int count;
        int r;
        for (int m = 0; m < 4; m++) begin
            wait_idle();
            write_probe_mode(probe_mode_t'(3 - m));
            src_idle_pct   = src_pct;
            sink_stall_pct = sink_pct;
            count = 0;
            while (count < ITEMS_PER_MODE) begin
                r = $urandom_range(99);
                if (r < 55) begin
                    send_request(REQ_INSERT, rand_key(), SLOT_W'($urandom));
                end else if (r < 88) begin
                    send_request(REQ_READ, KEY_W'($urandom), SLOT_W'($urandom));
                end else if (r < 94) begin
                    send_request(REQ_CLEAR, KEY_W'($urandom), SLOT_W'($urandom));
                end else begin
                    send_request(REQ_UNUSED, KEY_W'($urandom), SLOT_W'($urandom));
                end
                count++;
            end
        end
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_basic_requests();
        test_fill_to_full();
        test_random_traffic(0, 0);
        test_random_traffic(62, 0);
        test_random_traffic(0, 62);
        test_random_traffic(19, 19);
        src_idle_pct = 0;
        sink_stall_pct = 0;
        wait_idle();
        $display("Ran all four probe rules under four idle/stall patterns: %0d stored,",
                 n_stored);
        $display("%0d full, %0d read hits, %0d read misses, %0d clears, %0d dropped codes.",
                 n_full, n_hit, n_miss, n_clear, n_unused);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #10_000_000;
        $display("watchdog expired with %0d results pending", pending_results.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/oahi_pkg.sv
rtl/core/oahi_ram.sv
rtl/core/oahi_ctrl.sv
rtl/core/oahi_dp.sv
rtl/core/open_addressing_hash_insert_top.sv
tb/tb.sv
